// ===== rtl/swc_pkg.sv =====
`timescale 1ns / 1ps

package swc_pkg;

    localparam int DATA_W  = 32;
    localparam int CHECK_W = 7;
    localparam int SYN_W   = 8;
    localparam int BYTES   = DATA_W / 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Status codes
    localparam logic [1:0] STAT_CLEAN     = 2'd0;
    localparam logic [1:0] STAT_CORRECTED = 2'd1;
    localparam logic [1:0] STAT_UNCORR    = 2'd2;

    // Mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Parity rows, check bit i covers row i
    localparam logic [DATA_W-1:0] ROWS [CHECK_W] = '{
        32'hFF021283, 32'h09FF2484, 32'h1010FF36, 32'h222580FF,
        32'h65490F68, 32'h868EF808, 32'hD8F04151
    };

    // Column code of data bit (31 - k)
    localparam logic [SYN_W-1:0] COLUMNS [DATA_W] = '{
        8'h61, 8'h51, 8'h19, 8'h45, 8'h43, 8'h31, 8'h29, 8'h13,
        8'h62, 8'h52, 8'h4A, 8'h46, 8'h32, 8'h2A, 8'h23, 8'h1A,
        8'h2C, 8'h64, 8'h26, 8'h25, 8'h34, 8'h16, 8'h15, 8'h54,
        8'h0B, 8'h58, 8'h1C, 8'h4C, 8'h38, 8'h0E, 8'h0D, 8'h49
    };

    // Padded word after the first stage; byte_en[3] is the first byte
    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] word;
        logic [BYTES-1:0]  byte_en;
        logic [SYN_W-1:0]  check_in;
    } pad_t;

    // Check bits and syndrome after the second stage
    typedef struct packed {
        logic               mode;
        logic [DATA_W-1:0]  word;
        logic [BYTES-1:0]   byte_en;
        logic [CHECK_W-1:0] chk;
        logic [SYN_W-1:0]   syn;
    } syn_t;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic [CHECK_W-1:0] check_out;
        logic [DATA_W-1:0]  data_out;
    } res_t;

    // Byte enables from the count of leading bytes
    function automatic logic [BYTES-1:0] byte_enables(input logic [2:0] count);
        logic [BYTES-1:0] be;
        unique case (count)
            3'd0:    be = 4'b0000;
            3'd1:    be = 4'b1000;
            3'd2:    be = 4'b1100;
            3'd3:    be = 4'b1110;
            default: be = 4'b1111;
        endcase
        return be;
    endfunction

    // Expand byte enables into a bit mask
    function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTES-1:0] be);
        return {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
    endfunction

endpackage

// ===== rtl/swc_pad.sv =====
`timescale 1ns / 1ps

module swc_pad (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          mode,
    input  logic [31:0]   data_word,
    input  logic [2:0]    valid_bytes,
    input  logic [7:0]    check_in,
    output logic          out_valid,
    input  logic          out_ready,
    output swc_pkg::pad_t out_pad
);
    import swc_pkg::*;

    logic  valid_reg;
    pad_t  pad_reg;
    pad_t  pad_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pad   = pad_reg;

    // Zero the bytes past the valid count
    always_comb begin
        pad_next.mode     = mode;
        pad_next.byte_en  = byte_enables(valid_bytes);
        pad_next.word     = data_word & byte_mask(pad_next.byte_en);
        pad_next.check_in = check_in;
    end

    // Advance when the slot is empty or the next stage can take the held request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pad_reg <= pad_next;
        end
    end

endmodule

// ===== rtl/swc_syndrome.sv =====
`timescale 1ns / 1ps

module swc_syndrome (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  swc_pkg::pad_t in_pad,
    output logic          out_valid,
    input  logic          out_ready,
    output swc_pkg::syn_t out_syn
);
    import swc_pkg::*;

    logic  valid_reg;
    syn_t  syn_reg;
    syn_t  syn_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_syn   = syn_reg;

    // Parity of each masked row, then fold in the stored check byte
    always_comb begin
        syn_next.mode    = in_pad.mode;
        syn_next.word    = in_pad.word;
        syn_next.byte_en = in_pad.byte_en;
        for (int r = 0; r < CHECK_W; r++) begin
            syn_next.chk[r] = ^(in_pad.word & ROWS[r]);
        end
        syn_next.syn = in_pad.check_in ^ {1'b0, syn_next.chk};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            syn_reg <= syn_next;
        end
    end

endmodule

// ===== rtl/swc_correct.sv =====
`timescale 1ns / 1ps

module swc_correct (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  swc_pkg::syn_t in_syn,
    output logic          out_valid,
    input  logic          out_ready,
    output swc_pkg::res_t out_res
);
    import swc_pkg::*;

    logic              valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic [DATA_W-1:0] flip;
    logic              hit;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Match the syndrome against the columns; the lowest column index wins
    always_comb begin
        flip = '0;
        hit  = 1'b0;
        for (int k = DATA_W - 1; k >= 0; k--) begin
            if (in_syn.syn == COLUMNS[k]) begin
                flip = '0;
                flip[DATA_W-1-k] = 1'b1;
                hit  = 1'b1;
            end
        end
    end

    // Flip the matched bit in decode, keep padding bytes at zero
    always_comb begin
        res_next.check_out = in_syn.chk;
        res_next.data_out  = in_syn.word;
        res_next.status    = STAT_CLEAN;
        if (in_syn.mode == MODE_DECODE && in_syn.syn != '0) begin
            if (hit) begin
                res_next.data_out = (in_syn.word ^ flip) & byte_mask(in_syn.byte_en);
                res_next.status   = STAT_CORRECTED;
            end else begin
                res_next.status   = STAT_UNCORR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/secded_word_codec_core.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (low bit up)                          | tuser
// s_      | in  | data_word[31:0] valid_bytes[34:32] check_in[42:35] | mode
// m_      | out | data_out[31:0] check_out[38:32] status[40:39]      | -
//
// Registered stages in order: pad, parity/syndrome, column match/correct.
// One request per cycle is sustained; each stage has its own valid bit.
// A stall on m_ holds the output register; upstream stages keep filling
// their empty slots, so s_tready drops only once all three stages are full.
// Synchronous active-low reset clears the valid bits only.

module secded_word_codec_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // data_word, valid_bytes, check_in, unused
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // data_out, check_out, status, zero pad
);
    import swc_pkg::*;

    logic  pad_valid;
    logic  pad_ready;
    pad_t  pad;
    logic  syn_valid;
    logic  syn_ready;
    syn_t  syn;
    res_t  res;

    // Stage one: byte padding
    swc_pad u_pad (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .mode        (s_tuser[0]),
        .data_word   (s_tdata[31:0]),
        .valid_bytes (s_tdata[34:32]),
        .check_in    (s_tdata[42:35]),
        .out_valid   (pad_valid),
        .out_ready   (pad_ready),
        .out_pad     (pad)
    );

    // Stage two: check bits and syndrome
    swc_syndrome u_syn (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pad_valid),
        .in_ready  (pad_ready),
        .in_pad    (pad),
        .out_valid (syn_valid),
        .out_ready (syn_ready),
        .out_syn   (syn)
    );

    // Stage three: correction and status
    swc_correct u_cor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (syn_valid),
        .in_ready  (syn_ready),
        .in_syn    (syn),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {{(M_TDATA_W - $bits(res_t)){1'b0}}, res};

endmodule

// ===== rtl/swc_checker.sv =====
`timescale 1ns / 1ps

module swc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import swc_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Status never takes the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[40:39] <= STAT_UNCORR)
        else $error("bad status code");

    // An empty output stage means the whole pipe can take a request
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Drop all results on reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind secded_word_codec_core swc_checker u_swc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
